// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/dtq_pkg.sv -----
// types and constants of the delta timer queue
// no dependencies
package dtq_pkg;

	localparam int TAG_W   = 16;
	localparam int DELAY_W = 16;
	localparam int DELTA_W = 16;

	// item kinds
	localparam logic KIND_INSERT  = 1'b0;
	localparam logic KIND_ADVANCE = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_EXPIRED  = 2'd2,
		ST_NONE     = 2'd3
	} status_t;

	// commands from controller to datapath
	typedef struct packed {
		logic    ins_start;
		logic    adv_start;
		logic    pop_free;
		logic    walk_step;
		logic    walk_stop;
		logic    link1;
		logic    link2;
		logic    expire;
		logic    keep;
		logic    emit;
		status_t emit_status;
		logic    emit_last;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic in_insert;
		logic in_full;
		logic in_noop;
		logic has_t;
		logic walk_go;
		logic walk_last;
		logic due;
		logic held;
		logic more;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/dtq_in_if.sv -----
// input channel of the delta timer queue: valid/ready plus one item word
// depends on dtq_pkg
interface dtq_in_if;
	import dtq_pkg::*;

	logic               valid;
	logic               ready;
	logic               kind;
	logic [TAG_W-1:0]   timer_tag;
	logic [DELAY_W-1:0] delay_ticks;
	logic [DELAY_W-1:0] ticks_passed;

	modport source (output valid, kind, timer_tag, delay_ticks, ticks_passed, input ready);
	modport sink   (input valid, kind, timer_tag, delay_ticks, ticks_passed, output ready);
endinterface

// ----- rtl/dtq_out_if.sv -----
// result channel of the delta timer queue: valid/ready plus one result word
// depends on dtq_pkg
interface dtq_out_if;
	import dtq_pkg::*;

	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [TAG_W-1:0] expired_tag;
	logic             last;

	modport source (output valid, status, expired_tag, last, input ready);
	modport sink   (input valid, status, expired_tag, last, output ready);
endinterface

// ----- rtl/delta_timer_queue.sv -----
// Insert: pops a free entry, walks past the pending entries due strictly before it, then
// writes it and relinks its neighbours; a full queue reports full and stores nothing.
// Advance: expires entries from the head; each result word is registered at the output.
// One item in work at a time, set by the single read port of the entry rams walked per cycle.
// Reset clears the list pointers, counts and output valid at once; entry rams are not
// cleared, free entries are handed out by a fill count, so no clearing pass is needed.
module delta_timer_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input logic       clk,
	input logic       arst_n,
	dtq_in_if.sink    req,
	dtq_out_if.source rsp
);
	import dtq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing
	dtq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage and arithmetic
	dtq_dpath #(.DEPTH(QUEUE_DEPTH)) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.kind         (req.kind),
		.timer_tag    (req.timer_tag),
		.delay_ticks  (req.delay_ticks),
		.ticks_passed (req.ticks_passed),
		.cmd          (cmd),
		.sts          (sts),
		.rsp          (rsp)
	);
endmodule

// ----- rtl/dtq_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module dtq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ----- rtl/dtq_ctrl.sv -----
// controller state machine of the delta timer queue
// depends on dtq_pkg; drives the datapath through cmd_t, reads sts_t
module dtq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  dtq_pkg::sts_t sts,
	output dtq_pkg::cmd_t cmd
);
	import dtq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FULL,
		S_NONE,
		S_POP,
		S_WALK,
		S_LINK1,
		S_LINK2,
		S_ADV,
		S_ADV_LAST
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (sts.in_insert) begin
						if (sts.in_full) begin
							state_d = S_FULL;
						end else begin
							cmd.ins_start = 1'b1;
							state_d       = S_POP;
						end
					end else if (sts.in_noop) begin
						state_d = S_NONE;
					end else begin
						cmd.adv_start = 1'b1;
						state_d       = S_ADV;
					end
				end
			end
			S_FULL: begin
				if (sts.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_FULL;
					cmd.emit_last   = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_NONE: begin
				if (sts.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_NONE;
					cmd.emit_last   = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_POP: begin
				cmd.pop_free = 1'b1;
				state_d      = sts.has_t ? S_WALK : S_LINK1;
			end
			S_WALK: begin
				// one pending entry per cycle
				if (sts.walk_go) begin
					cmd.walk_step = 1'b1;
					if (sts.walk_last) begin
						state_d = S_LINK1;
					end
				end else begin
					cmd.walk_stop = 1'b1;
					state_d       = S_LINK1;
				end
			end
			S_LINK1: begin
				cmd.link1 = 1'b1;
				state_d   = S_LINK2;
			end
			S_LINK2: begin
				if (sts.out_free) begin
					cmd.link2       = 1'b1;
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_INSERTED;
					cmd.emit_last   = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_ADV: begin
				// one expired tag is held back until we know whether it is the last
				if (sts.due) begin
					if (!sts.held || sts.out_free) begin
						cmd.expire      = 1'b1;
						cmd.emit        = sts.held;
						cmd.emit_status = ST_EXPIRED;
						state_d         = sts.more ? S_ADV : S_ADV_LAST;
					end
				end else if (sts.out_free) begin
					cmd.keep        = 1'b1;
					cmd.emit        = 1'b1;
					cmd.emit_status = sts.held ? ST_EXPIRED : ST_NONE;
					cmd.emit_last   = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_ADV_LAST: begin
				if (sts.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_EXPIRED;
					cmd.emit_last   = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ----- rtl/dtq_dpath.sv -----
// datapath of the delta timer queue: entry rams, list pointers, output register
// depends on dtq_pkg, dtq_out_if and dtq_ram
module dtq_dpath #(
	parameter int DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        kind,
	input  logic [dtq_pkg::TAG_W-1:0]   timer_tag,
	input  logic [dtq_pkg::DELAY_W-1:0] delay_ticks,
	input  logic [dtq_pkg::DELAY_W-1:0] ticks_passed,
	input  dtq_pkg::cmd_t               cmd,
	output dtq_pkg::sts_t               sts,
	dtq_out_if.source                   rsp
);
	import dtq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	// list state
	logic [IDX_W-1:0]   head_q, free_q;
	logic [CNT_W-1:0]   count_q, fill_q, walked_q;
	// per-item work registers
	logic [DELTA_W-1:0] ticks_q, dcur_q;
	logic [DELAY_W-1:0] passed_q;
	logic [IDX_W-1:0]   cur_q, prev_q, fresh_q;
	logic               has_t_q, has_prev_q, first_q, held_q;
	logic [TAG_W-1:0]   held_tag_q;
	// output register
	logic               out_valid_q;
	status_t            out_status_q;
	logic [TAG_W-1:0]   out_tag_q;
	logic               out_last_q;

	// ram ports
	logic               d_we, d_re, n_we, n_re, t_we, t_re;
	logic [IDX_W-1:0]   d_waddr, d_raddr, n_waddr, n_raddr, t_waddr, t_raddr;
	logic [DELTA_W-1:0] d_wdata, d_rd;
	logic [IDX_W-1:0]   n_wdata, n_rd;
	logic [TAG_W-1:0]   t_rd;

	logic               from_fill;
	logic [IDX_W-1:0]   fill_idx, fill_succ;
	logic [DELTA_W-1:0] keep_val;

	dtq_ram #(.WIDTH(DELTA_W), .DEPTH(DEPTH)) u_delta_ram (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.re(d_re), .raddr(d_raddr), .rdata(d_rd)
	);

	dtq_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_next_ram (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.re(n_re), .raddr(n_raddr), .rdata(n_rd)
	);

	dtq_ram #(.WIDTH(TAG_W), .DEPTH(DEPTH)) u_tag_ram (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(timer_tag),
		.re(t_re), .raddr(t_raddr), .rdata(t_rd)
	);

	// never-used entries are handed out in index order, so their links need no init
	assign from_fill = (CNT_W'(free_q) == fill_q);
	assign fill_idx  = fill_q[IDX_W-1:0];
	assign fill_succ = (fill_idx == LAST_IDX) ? '0 : fill_idx + IDX_W'(1);
	assign keep_val  = first_q ? (d_rd - passed_q) : d_rd;

	// status to the controller
	always_comb begin
		sts.in_insert = (kind == KIND_INSERT);
		sts.in_full   = (count_q == CNT_W'(DEPTH));
		sts.in_noop   = (ticks_passed == '0) || (count_q == '0);
		sts.has_t     = has_t_q;
		sts.walk_go   = (ticks_q > d_rd);
		sts.walk_last = ((walked_q + CNT_W'(1)) == count_q);
		sts.due       = first_q ? (d_rd <= passed_q) : (d_rd == '0);
		sts.held      = held_q;
		sts.more      = (count_q != CNT_W'(1));
		sts.out_free  = !out_valid_q || rsp.ready;
	end

	// ram read addresses
	always_comb begin
		d_re    = 1'b0;
		d_raddr = head_q;
		n_re    = 1'b0;
		n_raddr = head_q;
		t_re    = 1'b0;
		t_raddr = head_q;
		if (cmd.ins_start) begin
			n_re    = 1'b1;
			n_raddr = free_q;
		end
		if (cmd.adv_start) begin
			d_re = 1'b1;
			n_re = 1'b1;
			t_re = 1'b1;
		end
		if (cmd.pop_free) begin
			d_re    = 1'b1;
			d_raddr = cur_q;
			n_re    = 1'b1;
			n_raddr = cur_q;
		end
		if (cmd.walk_step) begin
			d_re    = 1'b1;
			d_raddr = n_rd;
			n_re    = 1'b1;
			n_raddr = n_rd;
		end
		if (cmd.expire && sts.more) begin
			d_re    = 1'b1;
			d_raddr = n_rd;
			n_re    = 1'b1;
			n_raddr = n_rd;
			t_re    = 1'b1;
			t_raddr = n_rd;
		end
	end

	// ram writes
	always_comb begin
		d_we    = 1'b0;
		d_waddr = fresh_q;
		d_wdata = ticks_q;
		n_we    = 1'b0;
		n_waddr = fresh_q;
		n_wdata = has_t_q ? cur_q : '0;
		t_we    = cmd.ins_start;
		t_waddr = free_q;
		if (cmd.link1) begin
			d_we = 1'b1;
			n_we = 1'b1;
		end
		if (cmd.link2) begin
			d_we    = has_t_q;
			d_waddr = cur_q;
			d_wdata = dcur_q - ticks_q;
			n_we    = has_prev_q;
			n_waddr = prev_q;
			n_wdata = fresh_q;
		end
		if (cmd.keep) begin
			d_we    = 1'b1;
			d_waddr = head_q;
			d_wdata = keep_val;
		end
		if (cmd.expire) begin
			n_we    = 1'b1;
			n_waddr = head_q;
			n_wdata = free_q;
		end
	end

	// list control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			free_q     <= '0;
			count_q    <= '0;
			fill_q     <= '0;
			has_t_q    <= 1'b0;
			has_prev_q <= 1'b0;
			first_q    <= 1'b0;
			held_q     <= 1'b0;
		end else begin
			if (cmd.ins_start) begin
				has_t_q    <= (count_q != '0);
				has_prev_q <= 1'b0;
			end
			if (cmd.pop_free) begin
				if (from_fill) begin
					free_q <= fill_succ;
					fill_q <= fill_q + CNT_W'(1);
				end else begin
					free_q <= n_rd;
				end
			end
			if (cmd.walk_step) begin
				has_prev_q <= 1'b1;
				if (sts.walk_last) begin
					has_t_q <= 1'b0;
				end
			end
			if (cmd.link2) begin
				if (!has_prev_q) begin
					head_q <= fresh_q;
				end
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.adv_start) begin
				first_q <= 1'b1;
				held_q  <= 1'b0;
			end
			if (cmd.expire) begin
				held_q  <= 1'b1;
				first_q <= 1'b0;
				head_q  <= n_rd;
				free_q  <= head_q;
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		if (cmd.ins_start) begin
			ticks_q  <= (delay_ticks == '0) ? DELTA_W'(1) : delay_ticks;
			cur_q    <= head_q;
			fresh_q  <= free_q;
			walked_q <= '0;
		end
		if (cmd.walk_step) begin
			ticks_q  <= ticks_q - d_rd;
			prev_q   <= cur_q;
			cur_q    <= n_rd;
			walked_q <= walked_q + CNT_W'(1);
		end
		if (cmd.walk_stop) begin
			dcur_q <= d_rd;
		end
		if (cmd.adv_start) begin
			passed_q <= ticks_passed;
		end
		if (cmd.expire) begin
			held_tag_q <= t_rd;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= cmd.emit_status;
			out_tag_q    <= (cmd.emit_status == ST_EXPIRED) ? held_tag_q : '0;
			out_last_q   <= cmd.emit_last;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.expired_tag = out_tag_q;
	assign rsp.last        = out_last_q;
endmodule

// ----- rtl/dtq_checker.sv -----
// port-level assertions for the delta timer queue, bound to the top level
// depends on dtq_pkg, dtq_in_if, dtq_out_if and assert_macros.svh
`include "assert_macros.svh"

module dtq_checker (
	input logic       clk,
	input logic       arst_n,
	dtq_in_if.sink    req,
	dtq_out_if.source rsp
);
	import dtq_pkg::*;

	// a waiting result word stays and holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, rsp.valid && !rsp.ready, rsp.valid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, rsp.valid && !rsp.ready, $stable(rsp.status) && $stable(rsp.expired_tag) && $stable(rsp.last))
	// only expiries come in runs, every other result closes its item
	`ASSERT_IMPLY(a_single_last, clk, arst_n, rsp.valid && (rsp.status != ST_EXPIRED), rsp.last)
	`ASSERT_IMPLY(a_zero_tag, clk, arst_n, rsp.valid && (rsp.status != ST_EXPIRED), rsp.expired_tag == '0)
	// one item in work at a time
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready)
endmodule

bind delta_timer_queue dtq_checker u_dtq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);
